[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: field widths, operation
// codes, symbol codes and default screen geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 7;
  localparam int OFFS_W   = 11;
  localparam int CELL_W   = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PRINT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Symbol codes
  localparam logic [BYTE_W-1:0] SYM_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] SYM_SPACE   = 8'd32;

  // Register reset value
  localparam logic [BYTE_W-1:0] BLANK_ATTR_RST = 8'd15;

endpackage

[rtl/tcw_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_in_if / tcw_out_if
// Valid/ready channels for console commands and console results.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::OP_W-1:0]         operation;
  logic [tcw_pkg::BYTE_W-1:0]       symbol;
  logic [tcw_pkg::BYTE_W-1:0]       color;
  logic signed [tcw_pkg::COL_W-1:0] column;
  logic signed [tcw_pkg::ROW_W-1:0] row;
  logic [tcw_pkg::OFFS_W-1:0]       back_offset;
  logic [tcw_pkg::OFFS_W-1:0]       cell_index;

  modport source (output valid, operation, symbol, color, column, row, back_offset,
                  cell_index, input ready);
  modport sink   (input valid, operation, symbol, color, column, row, back_offset,
                  cell_index, output ready);
endinterface

interface tcw_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::OFFS_W-1:0] cursor_position;
  logic [tcw_pkg::BYTE_W-1:0] read_symbol;
  logic [tcw_pkg::BYTE_W-1:0] read_attribute;
  logic                       scrolled;

  modport source (output valid, cursor_position, read_symbol, read_attribute, scrolled,
                  input ready);
  modport sink   (input valid, cursor_position, read_symbol, read_attribute, scrolled,
                  output ready);
endinterface

[rtl/text_console_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode cell store with cursor, driven by a small sequencer around one
// cell memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
// Usage:
//   item   : command beats (print, delete, clear, read). ready is high only
//            while the sequencer is idle, so one command is worked at a time.
//   result : one beat per command with the cursor after the command, the cell
//            read (zero unless read) and a scroll flag. The result sits in an
//            output register; the next command is taken while it waits.
//   APB    : register 0 at byte address 0 holds the blank attribute.
// Steps, from the accepted command to result valid:
//   print and delete pick the position and back off; print then advances
//   the cursor, and a newline first does a line search by repeated
//   subtraction of COLUMNS. Read reads the cell and then captures it.
//   Scrolling copies every cell one line up through the memory port, one
//   cell a cycle, then blanks the bottom line. Clear writes every cell.
// Handshake: ready returns with the result beat, so the next command can be
//   taken while that beat waits; no command is taken while one is worked.
// Reset clears the cursor, the blank attribute (to 15) and the handshake
//   state; cell contents are undefined until printed or cleared.
// If the receiver stalls, the finished result holds and the sequencer waits
//   in its last step once the next command is worked.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tcw_in_if.sink                      item,
  tcw_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int POS_W = $clog2(CELLS);
  localparam int CW    = ((POS_W > tcw_pkg::OFFS_W) ? POS_W : tcw_pkg::OFFS_W) + 1;
  localparam logic [POS_W-1:0] LAST_CELL  = POS_W'(CELLS - 1);
  localparam logic [POS_W-1:0] LAST_LINE  = POS_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] LINE_CELLS = POS_W'(COLUMNS);

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_BACK  = 4'd2;
  localparam logic [3:0] S_LINE  = 4'd3;
  localparam logic [3:0] S_ADV   = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_BLANK = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_RDCAP = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                        state;
  logic [POS_W-1:0]                  cursor;
  logic [tcw_pkg::BYTE_W-1:0]        blank_attr;
  logic                              cp_valid;
  logic [POS_W-1:0]                  cp_addr;

  logic [tcw_pkg::OP_W-1:0]          op_r;
  logic [tcw_pkg::BYTE_W-1:0]        sym_r;
  logic [tcw_pkg::BYTE_W-1:0]        color_r;
  logic signed [tcw_pkg::COL_W-1:0]  col_r;
  logic signed [tcw_pkg::ROW_W-1:0]  row_r;
  logic [tcw_pkg::OFFS_W-1:0]        back_r;
  logic [tcw_pkg::OFFS_W-1:0]        index_r;
  logic [POS_W-1:0]                  base;
  logic [POS_W-1:0]                  pos;
  logic [POS_W-1:0]                  rem;
  logic [POS_W-1:0]                  idx;
  logic                              scr_flag;
  logic                              rd_ok;
  logic [tcw_pkg::BYTE_W-1:0]        rsym;
  logic [tcw_pkg::BYTE_W-1:0]        rattr;

  logic [tcw_pkg::CELL_W-1:0]        mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]        rd_data;
  logic                              we;
  logic [POS_W-1:0]                  wa;
  logic [tcw_pkg::CELL_W-1:0]        wd;
  logic                              re;
  logic [POS_W-1:0]                  ra;

  logic                              explicit_ok;
  logic [POS_W-1:0]                  base_next;
  logic [POS_W-1:0]                  pos_next;
  logic                              index_ok;
  logic                              out_free;
  logic                              cfg_wr;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : tcw_pkg::APB_DW'(blank_attr);

  assign item.ready = (state == S_IDLE);
  assign out_free   = !result.valid || result.ready;

  // Chosen position: explicit cell or cursor, clamped to the last cell
  always_comb begin
    explicit_ok = !col_r[tcw_pkg::COL_W-1] && (32'(col_r[tcw_pkg::COL_W-2:0]) < COLUMNS) &&
                  !row_r[tcw_pkg::ROW_W-1] && (32'(row_r[tcw_pkg::ROW_W-2:0]) < ROWS);
    if (explicit_ok) begin
      base_next = POS_W'(32'(row_r[tcw_pkg::ROW_W-2:0]) * COLUMNS +
                         32'(col_r[tcw_pkg::COL_W-2:0]));
    end else if (32'(cursor) >= CELLS) begin
      base_next = LAST_CELL;
    end else begin
      base_next = cursor;
    end
  end

  // Back off from the chosen position, saturating at zero
  always_comb begin
    if (CW'(back_r) >= CW'(base)) begin
      pos_next = '0;
    end else begin
      pos_next = POS_W'(CW'(base) - CW'(back_r));
    end
  end

  assign index_ok = (32'(index_r) < CELLS);

  // Memory port selection
  always_comb begin
    we = 1'b0;
    wa = pos_next;
    wd = {color_r, sym_r};
    re = 1'b0;
    ra = idx;
    if (cp_valid) begin
      we = 1'b1;
      wa = cp_addr;
      wd = rd_data;
    end else if (state == S_BLANK) begin
      we = 1'b1;
      wa = idx;
      wd = {blank_attr, tcw_pkg::SYM_SPACE};
    end else if (state == S_BACK) begin
      if (op_r == tcw_pkg::OP_DELETE) begin
        we = 1'b1;
        wd = {color_r, tcw_pkg::SYM_SPACE};
      end else if (sym_r != tcw_pkg::SYM_NEWLINE) begin
        we = 1'b1;
      end
    end
    if (state == S_COPY) begin
      re = 1'b1;
    end else if (state == S_READ) begin
      re = index_ok;
      ra = POS_W'(index_r);
    end
  end

  // Cell memory, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  // Hold the destination of the cell copy in flight
  always_ff @(posedge clk) begin
    cp_addr <= POS_W'(32'(idx) - COLUMNS);
    if (rst) begin
      cp_valid <= 1'b0;
    end else begin
      cp_valid <= (state == S_COPY);
    end
  end

  // Blank attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attr <= tcw_pkg::BLANK_ATTR_RST;
    end else if (cfg_wr) begin
      blank_attr <= pwdata[tcw_pkg::BYTE_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cursor       <= '0;
      result.valid <= 1'b0;
    end else begin
      // Load the result beat when a command finishes, drop it once taken
      if (state == S_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            op_r     <= item.operation;
            sym_r    <= item.symbol;
            color_r  <= item.color;
            col_r    <= item.column;
            row_r    <= item.row;
            back_r   <= item.back_offset;
            index_r  <= item.cell_index;
            rsym     <= '0;
            rattr    <= '0;
            scr_flag <= 1'b0;
            unique case (item.operation)
              tcw_pkg::OP_PRINT, tcw_pkg::OP_DELETE: begin
                state <= S_POS;
              end
              tcw_pkg::OP_CLEAR: begin
                idx    <= '0;
                cursor <= '0;
                state  <= S_BLANK;
              end
              default: begin
                state <= S_READ;
              end
            endcase
          end
        end
        S_POS: begin
          base  <= base_next;
          state <= S_BACK;
        end
        S_BACK: begin
          pos <= pos_next;
          rem <= pos_next;
          if (op_r == tcw_pkg::OP_DELETE) begin
            cursor <= pos_next;
            state  <= S_DONE;
          end else if (sym_r == tcw_pkg::SYM_NEWLINE) begin
            state <= S_LINE;
          end else begin
            state <= S_ADV;
          end
        end
        S_LINE: begin
          // Strip whole lines until the column remains, then jump to line end
          if (32'(rem) >= COLUMNS) begin
            rem <= rem - LINE_CELLS;
          end else begin
            pos   <= POS_W'(32'(pos) + COLUMNS - 1 - 32'(rem));
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (32'(pos) + 1 >= CELLS) begin
            idx      <= LINE_CELLS;
            scr_flag <= 1'b1;
            cursor   <= LAST_LINE;
            state    <= S_COPY;
          end else begin
            cursor <= pos + POS_W'(1);
            state  <= S_DONE;
          end
        end
        S_COPY: begin
          // Read one cell a cycle; the copy is written one line up from the registered read data
          if (idx == LAST_CELL) begin
            idx   <= LAST_LINE;
            state <= S_BLANK;
          end else begin
            idx <= idx + POS_W'(1);
          end
        end
        S_BLANK: begin
          if (!cp_valid) begin
            if (idx == LAST_CELL) begin
              state <= S_DONE;
            end else begin
              idx <= idx + POS_W'(1);
            end
          end
        end
        S_READ: begin
          rd_ok <= index_ok;
          state <= S_RDCAP;
        end
        S_RDCAP: begin
          rsym  <= rd_ok ? rd_data[tcw_pkg::BYTE_W-1:0] : '0;
          rattr <= rd_ok ? rd_data[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W] : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result.cursor_position <= tcw_pkg::OFFS_W'(cursor);
            result.read_symbol     <= rsym;
            result.read_attribute  <= rattr;
            result.scrolled        <= scr_flag;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tcw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tcw_pkg::OFFS_W-1:0] cursor_position,
  input logic [tcw_pkg::BYTE_W-1:0] read_symbol,
  input logic [tcw_pkg::BYTE_W-1:0] read_attribute,
  input logic                       scrolled
);

  localparam int CELLS = COLUMNS * ROWS;

  // Drop ready after taking a command: one command is worked at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in progress");

  // Hold a stalled result beat
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_position) &&
      $stable(read_symbol) && $stable(read_attribute) && $stable(scrolled))
    else $error("stalled result changed");

  // Keep the cursor on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(cursor_position) < CELLS)
    else $error("cursor beyond last cell");

  // A scroll leaves the cursor at the start of the bottom line
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> 32'(cursor_position) == (CELLS - COLUMNS) % 2048)
    else $error("cursor not on bottom line after scroll");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(item.valid),
  .in_ready(item.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .cursor_position(result.cursor_position),
  .read_symbol(result.read_symbol),
  .read_attribute(result.read_attribute),
  .scrolled(result.scrolled)
);

[bench/text_console_writer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_test
// Self-checking bench for the text console writer. It keeps its own model
// of the screen cells, the cursor and the blank attribute, and predicts one
// status beat for every accepted command. Each status beat that comes back is
// checked field by field against the oldest prediction. The run starts with
// a directed pass over the corner cases. A pass over both extremes of the
// blank attribute follows. Then come random phases, each under its own blank
// attribute, with random idle bursts on both channels and none in the last.
// ----------------------------------------------------------------------------
module text_console_writer_top_test;
  import tcw_pkg::*;

  localparam int PERIOD         = 10;
  localparam int COLUMNS        = COLUMNS_DEF;
  localparam int ROWS           = ROWS_DEF;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int WATCHDOG_LIMIT = 4 * (CELLS + ROWS + 64);
  localparam int SETTLE_CYCLES  = 20;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [APB_AW-1:0] REG_BLANK_ATTR = '0;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [BYTE_W-1:0]       symbol;
    logic [BYTE_W-1:0]       color;
    logic signed [COL_W-1:0] column;
    logic signed [ROW_W-1:0] row;
    logic [OFFS_W-1:0]       back_offset;
    logic [OFFS_W-1:0]       cell_index;
  } console_cmd_t;

  typedef struct {
    logic [OFFS_W-1:0] cursor;
    logic [BYTE_W-1:0] rd_symbol;
    logic [BYTE_W-1:0] rd_attr;
    logic              scrolled;
  } console_status_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tcw_in_if  cmd_bus ();
  tcw_out_if status_bus ();

  text_console_writer_top dut (
    .clk     (clk),
    .rst     (rst),
    .item    (cmd_bus),
    .result  (status_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Screen model and predicted status beats
  logic [CELL_W-1:0] screen [CELLS];
  int                cursor_model;
  logic [BYTE_W-1:0] blank_attr_model;
  console_status_t   status_q [$];

  bit idle_on;
  int ready_hold = 0;
  int quiet_cycles = 0;
  int fault_count = 0;
  int n_print = 0, n_delete = 0, n_clear = 0, n_read = 0, n_scroll = 0;
  int n_attr_writes = 0;

  initial clk = 1'b0;
  always #(PERIOD / 2) clk = ~clk;

  task automatic note_failure(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Position after the explicit/cursor choice and the saturating back-off
  function automatic int target_cell(input console_cmd_t c);
    int col, rw, pos;
    col = int'(c.column);
    rw  = int'(c.row);
    if (col >= 0 && col < COLUMNS && rw >= 0 && rw < ROWS) pos = rw * COLUMNS + col;
    else pos = cursor_model;
    if (pos >= CELLS) pos = CELLS - 1;
    return (int'(c.back_offset) >= pos) ? 0 : pos - int'(c.back_offset);
  endfunction

  // Apply one command to the screen model and return the status it reports
  function automatic console_status_t run_console_op(input console_cmd_t c);
    console_status_t s;
    int pos, i;
    s = '{default: '0};
    case (c.op)
      OP_PRINT: begin
        pos = target_cell(c);
        if (c.symbol == SYM_NEWLINE) pos = pos + COLUMNS - (pos % COLUMNS) - 1;
        else screen[pos] = {c.color, c.symbol};
        if (pos + 1 >= CELLS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {blank_attr_model, SYM_SPACE};
          cursor_model = CELLS - COLUMNS;
          s.scrolled = 1'b1;
        end else begin
          cursor_model = pos + 1;
        end
      end
      OP_DELETE: begin
        pos = target_cell(c);
        screen[pos] = {c.color, SYM_SPACE};
        cursor_model = pos;
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {blank_attr_model, SYM_SPACE};
        cursor_model = 0;
      end
      OP_READ: begin
        if (int'(c.cell_index) < CELLS) begin
          s.rd_symbol = screen[c.cell_index][7:0];
          s.rd_attr   = screen[c.cell_index][15:8];
        end
      end
    endcase
    s.cursor = cursor_model[OFFS_W-1:0];
    return s;
  endfunction

  function automatic console_cmd_t make_cmd(input logic [OP_W-1:0] op, input int symbol,
                                            input int color, input int column, input int row,
                                            input int back, input int idx);
    console_cmd_t c;
    c.op          = op;
    c.symbol      = BYTE_W'(symbol);
    c.color       = BYTE_W'(color);
    c.column      = COL_W'(column);
    c.row         = ROW_W'(row);
    c.back_offset = OFFS_W'(back);
    c.cell_index  = OFFS_W'(idx);
    return c;
  endfunction

  // Random command, biased toward positions that land and reads of fresh cells
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    c = make_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), -1, -1, 0,
                 $urandom_range(0, CELLS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) c.op = OP_PRINT;
    else if (pick < 67) c.op = OP_DELETE;
    else if (pick < 70) c.op = OP_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.column = COL_W'($urandom_range(0, COLUMNS - 1));
      c.row    = ROW_W'($urandom_range(0, ROWS - 1));
    end else if (pick < 50) begin
      c.column = COL_W'($urandom_range(0, 1) ? COLUMNS - 1 : $urandom_range(0, COLUMNS - 1));
      c.row    = ROW_W'(ROWS - 1);
    end else if (pick < 70) begin
      c.column = COL_W'($urandom);
      c.row    = ROW_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) c.back_offset = OFFS_W'($urandom_range(0, 2047));
    else if (pick < 40) c.back_offset = OFFS_W'($urandom_range(1, 6));
    if ($urandom_range(0, 99) < 15) c.symbol = SYM_NEWLINE;
    pick = $urandom_range(0, 99);
    if (pick < 40) c.cell_index = OFFS_W'((cursor_model > 0) ? cursor_model - 1 : 0);
    else if (pick < 55) c.cell_index = OFFS_W'($urandom_range(0, 2047));
    return c;
  endfunction

  // Send one command beat; predict its status at the accepting edge
  task automatic send_cmd(input console_cmd_t c);
    console_status_t s;
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.operation   <= c.op;
    cmd_bus.symbol      <= c.symbol;
    cmd_bus.color       <= c.color;
    cmd_bus.column      <= c.column;
    cmd_bus.row         <= c.row;
    cmd_bus.back_offset <= c.back_offset;
    cmd_bus.cell_index  <= c.cell_index;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    s = run_console_op(c);
    status_q.push_back(s);
    case (c.op)
      OP_PRINT:  n_print++;
      OP_DELETE: n_delete++;
      OP_CLEAR:  n_clear++;
      OP_READ:   n_read++;
    endcase
    if (s.scrolled) n_scroll++;
  endtask

  // Drop valid and hold until every predicted status beat has come back
  task automatic wait_all_reported();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the blank attribute over APB, then read it back
  task automatic write_blank_attr(input logic [BYTE_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLANK_ATTR;
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    blank_attr_model = value;
    n_attr_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(value))
      note_failure($sformatf("blank attribute readback exp %0h got %0h", value, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Corner cases under the reset blank attribute; clear comes first so that
  // no read ever touches a cell that was never written
  task automatic test_directed_ops();
    send_cmd(make_cmd(OP_CLEAR, 0, 0, -1, -1, 0, 0));
    send_cmd(make_cmd(OP_PRINT, 65, 8'h00, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_PRINT, 255, 8'hFF, -1, -1, 0, 0));
    // strict limits: column COLUMNS and row ROWS fall back to the cursor
    send_cmd(make_cmd(OP_PRINT, 0, 8'h5A, COLUMNS, 0, 0, 0));
    send_cmd(make_cmd(OP_PRINT, 66, 8'h21, 0, ROWS, 0, 0));
    send_cmd(make_cmd(OP_PRINT, 67, 8'h42, 127, 63, 0, 0));
    send_cmd(make_cmd(OP_PRINT, 68, 8'h84, -128, -64, 0, 0));
    // last cell scrolls the screen, then a newline on the bottom line
    send_cmd(make_cmd(OP_PRINT, 90, 8'h1E, COLUMNS - 1, ROWS - 1, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, CELLS - COLUMNS - 1));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, CELLS - COLUMNS));
    send_cmd(make_cmd(OP_PRINT, SYM_NEWLINE, 0, -1, -1, 0, 0));
    // back-off saturation, at and far beyond the position
    send_cmd(make_cmd(OP_PRINT, 97, 8'h07, 10, 3, 2047, 0));
    send_cmd(make_cmd(OP_PRINT, 98, 8'h70, 5, 0, 5, 0));
    send_cmd(make_cmd(OP_DELETE, 0, 8'hA5, 40, 12, 0, 0));
    send_cmd(make_cmd(OP_DELETE, 0, 8'h3C, -1, -1, 3, 0));
    send_cmd(make_cmd(OP_PRINT, SYM_NEWLINE, 0, 0, 7, 0, 0));
    send_cmd(make_cmd(OP_PRINT, SYM_NEWLINE, 0, COLUMNS - 1, 5, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, 12 * COLUMNS + 40));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, CELLS - 1));
    // reads past the last cell return zero
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, CELLS));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, 2047));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 3, 3, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, 555));
    wait_all_reported();
  endtask

  // Both extremes of the blank attribute through clear and scroll
  task automatic test_blank_attribute();
    int k;
    for (k = 0; k < 2; k++) begin
      write_blank_attr(k ? 8'hFF : 8'h00);
      send_cmd(make_cmd(OP_CLEAR, 0, 0, -1, -1, 0, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, 7 + k));
      send_cmd(make_cmd(OP_PRINT, 120, 8'h96, COLUMNS - 1, ROWS - 1, 0, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, CELLS - 50));
      send_cmd(make_cmd(OP_READ, 0, 0, -1, -1, 0, CELLS - COLUMNS - 1));
      wait_all_reported();
    end
  endtask

  // Random commands, with an occasional full drain mid-stream
  task automatic test_random_traffic(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_cmd(random_cmd());
      if ($urandom_range(0, 49) == 0) wait_all_reported();
    end
    wait_all_reported();
  endtask

  // Status sink: random stall bursts while idling is on
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      status_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 17);
      status_bus.ready <= 1'b0;
    end else begin
      status_bus.ready <= 1'b1;
    end
  end

  // Check each status beat against the oldest prediction
  always @(posedge clk) begin
    console_status_t want;
    if (!rst && status_bus.valid && status_bus.ready) begin
      if (status_q.size() == 0) begin
        note_failure($sformatf("status beat with nothing predicted, cursor %0d",
                               status_bus.cursor_position));
      end else begin
        want = status_q.pop_front();
        if (status_bus.cursor_position !== want.cursor)
          note_failure($sformatf("cursor exp %0d got %0d", want.cursor,
                                 status_bus.cursor_position));
        if (status_bus.read_symbol !== want.rd_symbol)
          note_failure($sformatf("read symbol exp %0h got %0h", want.rd_symbol,
                                 status_bus.read_symbol));
        if (status_bus.read_attribute !== want.rd_attr)
          note_failure($sformatf("read attribute exp %0h got %0h", want.rd_attr,
                                 status_bus.read_attribute));
        if (status_bus.scrolled !== want.scrolled)
          note_failure($sformatf("scroll flag exp %0b got %0b", want.scrolled,
                                 status_bus.scrolled));
      end
    end
  end

  // Watchdog: too long with no beat on either channel ends the run
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (status_bus.valid && status_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d status beats outstanding",
               quiet_cycles, status_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int phase;
    rst                   = 1'b1;
    idle_on               = 1'b1;
    cmd_bus.valid         = 1'b0;
    cmd_bus.operation     = OP_PRINT;
    cmd_bus.symbol        = '0;
    cmd_bus.color         = '0;
    cmd_bus.column        = '0;
    cmd_bus.row           = '0;
    cmd_bus.back_offset   = '0;
    cmd_bus.cell_index    = '0;
    status_bus.ready      = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cursor_model          = 0;
    blank_attr_model      = BLANK_ATTR_RST;
    foreach (screen[i]) screen[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_blank_attribute();
    for (phase = 0; phase < 4; phase++) begin
      idle_on = (phase < 3);
      write_blank_attr(BYTE_W'($urandom_range(1, 254)));
      test_random_traffic(100);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d prints, %0d deletes, %0d clears, %0d reads; %0d scrolls",
             n_print, n_delete, n_clear, n_read, n_scroll);
    $display("blank attribute written %0d times; %0d mismatches", n_attr_writes,
             fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
